FILE: hw/rtl/jsud_pkg.sv
// Shared types and constants for the JSON string byte decoder.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package jsud_pkg;

  // Size of the byte-level alphabet (codepoints 0..511).
  localparam int unsigned ALPHABET_SIZE = 512;

  // Default depth of the command queue between front and back end.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Width of a decoded codepoint.
  localparam int unsigned CP_W = 21;

  // Front-end decode phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX1    = 3'd2,
    PH_HIGH_BS = 3'd3,
    PH_HIGH_U  = 3'd4,
    PH_HEX2    = 3'd5,
    PH_UTF8    = 3'd6
  } jsud_phase_t;

  // Error codes carried in a result.
  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_TRUNC_HEX    = 4'd1,
    ERR_BAD_HEX      = 4'd2,
    ERR_TRAIL_BSLASH = 4'd3,
    ERR_UNPAIRED_HI  = 4'd4,
    ERR_BAD_PAIR     = 4'd5,
    ERR_UNPAIRED_LO  = 4'd6,
    ERR_UNKNOWN_ESC  = 4'd7,
    ERR_BAD_LEAD     = 4'd8,
    ERR_TRUNC_UTF8   = 4'd9,
    ERR_BAD_CONT     = 4'd10,
    ERR_OUTSIDE_ALPH = 4'd11
  } jsud_err_t;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } jsud_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       run_last;
    logic       string_end;
  } jsud_out_t;

  // Command from the front end: a codepoint to emit, or an error.
  typedef struct packed {
    jsud_err_t       err;
    logic [CP_W-1:0] cp;
    logic            last;
  } jsud_cmd_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } jsud_qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/json_string_utf8_byte_decoder.sv
// JSON string body decoder. One raw byte of a string body is accepted per
// clock (in_valid high, in_stall low); the byte with in_last ends the string.
// Escapes, \uXXXX groups with surrogate pairs and UTF-8 sequences are decoded
// to codepoints, which come out as 1 to 4 UTF-8 bytes (cfg_data = 0) or as
// one byte of the 512-entry byte-level alphabet (cfg_data = 1), one result
// byte per clock while out_stall is low. An error gives one result with a
// zero byte and its code, and the rest of that string then gives nothing.
// The front end takes a byte every cycle while the command queue
// (QUEUE_DEPTH entries) has room; the back end drains one result byte per
// cycle while out_stall is low; a result passes through the command queue
// and the output register. Write the mode only while the block is idle.
// Depends on jsud_pkg, jsud_front, jsud_fifo and jsud_back.
`default_nettype none

module json_string_utf8_byte_decoder #(
  parameter int unsigned QUEUE_DEPTH = jsud_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jsud_pkg::jsud_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jsud_pkg::jsud_out_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);
  import jsud_pkg::*;

  logic        mode_r;
  logic        cmd_valid;
  jsud_cmd_t   cmd;
  jsud_cmd_t   head_cmd;
  jsud_qstat_t qstat;
  logic        pop;

  // Mode register, written by a configuration transfer.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  jsud_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_level_mode (mode_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .qstat           (qstat),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd)
  );

  jsud_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  jsud_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_level_mode (mode_r),
    .qstat           (qstat),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/jsud_front.sv
// Front end: accepts string bytes, runs the escape and UTF-8 decode state
// machine and pushes codepoint or error commands. Depends on jsud_pkg.
`default_nettype none

module jsud_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_level_mode,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire jsud_pkg::jsud_in_t   in_data,
  input  wire jsud_pkg::jsud_qstat_t qstat,
  output logic                      cmd_valid,
  output jsud_pkg::jsud_cmd_t       cmd
);
  import jsud_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] ALPH_LIMIT = CP_W'(ALPHABET_SIZE);

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'b0_0000;
    end
    return r;
  endfunction

  // High when a codepoint has no byte in the byte-level alphabet.
  function automatic logic alph_miss(input logic [CP_W-1:0] c);
    logic miss;
    if (c >= ALPH_LIMIT) begin
      miss = 1'b1;
    end else if (!c[8]) begin
      miss = !((c[7:0] >= 8'd33 && c[7:0] <= 8'd126) ||
               (c[7:0] >= 8'd161 && c[7:0] <= 8'd172) || c[7:0] >= 8'd174);
    end else begin
      miss = (c[7:0] > 8'd67);
    end
    return miss;
  endfunction

  jsud_phase_t      phase_r, phase_nxt;
  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [9:0]       high_r, high_nxt;
  logic [1:0]       left_r, left_nxt;
  logic             bad_r, bad_nxt;
  logic             drop_r, drop_nxt;

  logic             in_fire;
  logic [7:0]       b;
  logic             last;
  logic [4:0]       hd;
  logic [15:0]      hv;
  logic             emit;
  logic             fail;
  logic [CP_W-1:0]  cp_v;
  jsud_err_t        err_v;

  assign in_stall = qstat.full;
  assign in_fire  = in_valid && !in_stall;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;
  assign hd       = hex_digit(b);
  assign hv       = {partial_r[11:0], hd[3:0]};

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= 2'd0;
      bad_r   <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      bad_r   <= bad_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Partial codepoint and high surrogate half carry no reset.
  always_ff @(posedge clk) begin
    partial_r <= partial_nxt;
    high_r    <= high_nxt;
  end

  // Next state and command for one accepted byte.
  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    high_nxt    = high_r;
    left_nxt    = left_r;
    bad_nxt     = bad_r;
    drop_nxt    = drop_r;
    emit        = 1'b0;
    fail        = 1'b0;
    cp_v        = '0;
    err_v       = ERR_NONE;
    if (in_fire) begin
      if (drop_r) begin
        // Dropping the rest of a failed string.
        drop_nxt  = !last;
        phase_nxt = PH_IDLE;
        left_nxt  = 2'd0;
        bad_nxt   = 1'b0;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (b == CH_BSLASH) begin
              if (last) begin
                fail  = 1'b1;
                err_v = ERR_TRAIL_BSLASH;
              end else begin
                phase_nxt = PH_ESC;
              end
            end else if (!b[7]) begin
              emit = 1'b1;
              cp_v = {13'd0, b};
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
              if (last) begin
                fail  = 1'b1;
                err_v = ERR_TRUNC_UTF8;
              end else begin
                phase_nxt = PH_UTF8;
                bad_nxt   = 1'b0;
                if (b[7:5] == 3'b110) begin
                  partial_nxt = {16'd0, b[4:0]};
                  left_nxt    = 2'd0;
                end else if (b[7:4] == 4'b1110) begin
                  partial_nxt = {17'd0, b[3:0]};
                  left_nxt    = 2'd1;
                end else begin
                  partial_nxt = {18'd0, b[2:0]};
                  left_nxt    = 2'd2;
                end
              end
            end else begin
              fail  = 1'b1;
              err_v = ERR_BAD_LEAD;
            end
          end
          PH_ESC: begin
            case (b)
              CH_QUOTE: begin emit = 1'b1; cp_v = 21'h22; end
              CH_BSLASH: begin emit = 1'b1; cp_v = 21'h5C; end
              CH_SLASH: begin emit = 1'b1; cp_v = 21'h2F; end
              CH_B: begin emit = 1'b1; cp_v = 21'h08; end
              CH_F: begin emit = 1'b1; cp_v = 21'h0C; end
              CH_N: begin emit = 1'b1; cp_v = 21'h0A; end
              CH_R: begin emit = 1'b1; cp_v = 21'h0D; end
              CH_T: begin emit = 1'b1; cp_v = 21'h09; end
              CH_U: begin
                if (last) begin
                  fail  = 1'b1;
                  err_v = ERR_TRUNC_HEX;
                end else begin
                  phase_nxt   = PH_HEX1;
                  left_nxt    = 2'd3;
                  partial_nxt = '0;
                  bad_nxt     = 1'b0;
                end
              end
              default: begin
                fail  = 1'b1;
                err_v = ERR_UNKNOWN_ESC;
              end
            endcase
          end
          PH_HEX1, PH_HEX2: begin
            partial_nxt = {5'd0, hv};
            bad_nxt     = bad_r | !hd[4];
            if (left_r != 2'd0) begin
              if (last) begin
                fail  = 1'b1;
                err_v = ERR_TRUNC_HEX;
              end else begin
                left_nxt = left_r - 2'd1;
              end
            end else if (bad_nxt) begin
              fail  = 1'b1;
              err_v = ERR_BAD_HEX;
            end else if (phase_r == PH_HEX2) begin
              // Low half of a surrogate pair.
              if (hv[15:10] != SURR_LO_TAG) begin
                fail  = 1'b1;
                err_v = ERR_BAD_PAIR;
              end else begin
                emit = 1'b1;
                cp_v = SUPP_BASE + {1'b0, high_r, hv[9:0]};
              end
            end else if (hv[15:10] == SURR_HI_TAG) begin
              if (last) begin
                fail  = 1'b1;
                err_v = ERR_UNPAIRED_HI;
              end else begin
                high_nxt    = hv[9:0];
                partial_nxt = '0;
                phase_nxt   = PH_HIGH_BS;
              end
            end else if (hv[15:10] == SURR_LO_TAG) begin
              fail  = 1'b1;
              err_v = ERR_UNPAIRED_LO;
            end else begin
              emit = 1'b1;
              cp_v = {5'd0, hv};
            end
          end
          PH_HIGH_BS: begin
            if (b != CH_BSLASH || last) begin
              fail  = 1'b1;
              err_v = ERR_UNPAIRED_HI;
            end else begin
              phase_nxt = PH_HIGH_U;
            end
          end
          PH_HIGH_U: begin
            if (b != CH_U) begin
              fail  = 1'b1;
              err_v = ERR_UNPAIRED_HI;
            end else if (last) begin
              fail  = 1'b1;
              err_v = ERR_TRUNC_HEX;
            end else begin
              phase_nxt   = PH_HEX2;
              left_nxt    = 2'd3;
              partial_nxt = '0;
              bad_nxt     = 1'b0;
            end
          end
          PH_UTF8: begin
            partial_nxt = {partial_r[14:0], b[5:0]};
            bad_nxt     = bad_r | (b[7:6] != 2'b10);
            if (left_r != 2'd0) begin
              if (last) begin
                fail  = 1'b1;
                err_v = ERR_TRUNC_UTF8;
              end else begin
                left_nxt = left_r - 2'd1;
              end
            end else if (bad_nxt) begin
              fail  = 1'b1;
              err_v = ERR_BAD_CONT;
            end else begin
              emit = 1'b1;
              cp_v = partial_nxt;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
        // A finished codepoint or an error ends the sequence.
        if (emit || fail) begin
          phase_nxt = PH_IDLE;
          left_nxt  = 2'd0;
          bad_nxt   = 1'b0;
        end
        if (fail && !last) begin
          drop_nxt = 1'b1;
        end
        // The back end turns a codepoint without an alphabet byte into an
        // error, so the rest of that string is dropped here as well.
        if (emit && byte_level_mode && alph_miss(cp_v) && !last) begin
          drop_nxt = 1'b1;
        end
        // The end of a string always returns to idle.
        if (last) begin
          phase_nxt = PH_IDLE;
          left_nxt  = 2'd0;
          bad_nxt   = 1'b0;
          drop_nxt  = 1'b0;
        end
      end
    end
  end

  // Command toward the queue.
  assign cmd_valid = in_fire && !drop_r && (emit || fail);
  assign cmd.err   = fail ? err_v : ERR_NONE;
  assign cmd.cp    = fail ? '0 : cp_v;
  assign cmd.last  = last;

endmodule

`default_nettype wire

FILE: hw/rtl/jsud_fifo.sv
// Command queue between the decoder front end and the byte back end.
// Depends on jsud_pkg for the command and status types.
`default_nettype none

module jsud_fifo #(
  parameter int unsigned DEPTH = jsud_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire jsud_pkg::jsud_cmd_t   push_cmd,
  input  wire logic                  pop,
  output jsud_pkg::jsud_cmd_t        head_cmd,
  output jsud_pkg::jsud_qstat_t      qstat
);
  import jsud_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  jsud_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_MAX) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_MAX) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  assign head_cmd    = mem_r[rptr_r];
  assign qstat.full  = (count_r == CNT_MAX);
  assign qstat.empty = (count_r == '0);

  // The front end must never write a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full && !pop))
    else $error("command pushed into a full queue");

  // The back end must never take from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty))
    else $error("command popped from an empty queue");

  // The fill count goes up by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count lost a push");

endmodule

`default_nettype wire

FILE: hw/rtl/jsud_back.sv
// Back end: takes codepoint commands from the queue and delivers result bytes,
// as UTF-8 or through the byte-level alphabet. Depends on jsud_pkg.
`default_nettype none

module jsud_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_level_mode,
  input  wire jsud_pkg::jsud_qstat_t qstat,
  input  wire jsud_pkg::jsud_cmd_t   head_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output jsud_pkg::jsud_out_t        out_data
);
  import jsud_pkg::*;

  localparam logic [CP_W-1:0] ALPH_LIMIT = CP_W'(ALPHABET_SIZE);

  logic [3:0][7:0] enc_bytes;
  logic [1:0]      enc_left;
  jsud_err_t       enc_err;
  logic [CP_W-1:0] cp;
  logic [7:0]      n;

  logic [3:0][7:0] buf_r;
  logic [1:0]      left_r;
  jsud_err_t       err_r;
  logic            end_r;
  logic            valid_r;
  logic            out_fire;

  assign cp = head_cmd.cp;
  assign n  = cp[7:0];

  // Expand the head command into its result bytes.
  always_comb begin
    enc_bytes = '0;
    enc_left  = 2'd0;
    enc_err   = head_cmd.err;
    if (head_cmd.err != ERR_NONE) begin
      enc_bytes = '0;
    end else if (byte_level_mode) begin
      if (cp >= ALPH_LIMIT) begin
        enc_err = ERR_OUTSIDE_ALPH;
      end else if (!cp[8]) begin
        if ((n >= 8'd33 && n <= 8'd126) || (n >= 8'd161 && n <= 8'd172) || n >= 8'd174) begin
          enc_bytes[0] = n;
        end else begin
          enc_err = ERR_OUTSIDE_ALPH;
        end
      end else if (n < 8'd33) begin
        enc_bytes[0] = n;
      end else if (n < 8'd67) begin
        enc_bytes[0] = n + 8'd94;
      end else if (n == 8'd67) begin
        enc_bytes[0] = 8'd173;
      end else begin
        enc_err = ERR_OUTSIDE_ALPH;
      end
    end else if (cp[20:7] == '0) begin
      enc_bytes[0] = cp[7:0];
    end else if (cp[20:11] == '0) begin
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
      enc_left     = 2'd1;
    end else if (cp[20:16] == '0) begin
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
      enc_left     = 2'd2;
    end else begin
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
      enc_left     = 2'd3;
    end
  end

  // Load the next command when the output buffer frees up.
  assign out_fire = valid_r && !out_stall;
  assign pop      = !qstat.empty && (!valid_r || (out_fire && left_r == 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      left_r  <= 2'd0;
    end else if (pop) begin
      valid_r <= 1'b1;
      left_r  <= enc_left;
    end else if (out_fire) begin
      if (left_r == 2'd0) begin
        valid_r <= 1'b0;
      end else begin
        left_r <= left_r - 2'd1;
      end
    end
  end

  // Byte buffer shifts one byte out per transfer.
  always_ff @(posedge clk) begin
    if (pop) begin
      buf_r <= enc_bytes;
      err_r <= enc_err;
      end_r <= head_cmd.last;
    end else if (out_fire) begin
      buf_r <= {8'h00, buf_r[3:1]};
    end
  end

  assign out_valid           = valid_r;
  assign out_data.out_byte   = buf_r[0];
  assign out_data.error_code = err_r;
  assign out_data.run_last   = (left_r == 2'd0);
  assign out_data.string_end = end_r;

  // An error result is a single zero byte.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && err_r != ERR_NONE) |-> (left_r == 2'd0 && buf_r[0] == 8'h00))
    else $error("error result is not a single zero byte");

  // A multi-byte codepoint keeps the buffer busy after a middle transfer.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && left_r != 2'd0) |=> (valid_r && left_r == $past(left_r) - 2'd1))
    else $error("codepoint bytes cut short");

endmodule

`default_nettype wire

FILE: test/json_string_utf8_byte_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_string_utf8_byte_decoder: directed and random
// string bodies in both output modes, with an in-bench decoder as predictor.
// Depends on jsud_pkg and the json_string_utf8_byte_decoder RTL.

module json_string_utf8_byte_decoder_tb;
  import jsud_pkg::*;

  // Characters that carry meaning inside a string body.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic MODE_UTF8 = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  localparam int CFG_SETTLE  = 12;
  localparam int END_SETTLE  = 20;
  localparam int QUIET_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  jsud_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  jsud_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  json_string_utf8_byte_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Decoder state kept by the bench, mirroring what the block must hold.
  logic        byte_mode = MODE_UTF8;
  jsud_phase_t dec_phase = PH_IDLE;
  logic [20:0] dec_acc = '0;
  logic [9:0]  dec_high = '0;
  logic [1:0]  dec_left = '0;
  logic        dec_bad = 1'b0;
  logic        dec_drop = 1'b0;
  jsud_out_t   decoded_due[$];

  int   errors = 0;
  int   sent_items = 0;
  bit   in_idle_on = 1'b0;
  bit   out_idle_on = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  logic [7:0] str_bytes[$];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_decode();
    dec_phase = PH_IDLE;
    dec_acc   = '0;
    dec_high  = '0;
    dec_left  = '0;
    dec_bad   = 1'b0;
  endfunction

  function automatic void push_result(logic [7:0] b, jsud_err_t e, logic run_last, logic last);
    jsud_out_t r;
    r.out_byte   = b;
    r.error_code = e;
    r.run_last   = run_last;
    r.string_end = last;
    decoded_due = {decoded_due, r};
  endfunction

  // An error is one result; the rest of an unfinished string is dropped.
  function automatic void report_error(jsud_err_t e, logic last);
    push_result(8'h00, e, 1'b1, last);
    clear_decode();
    if (!last) dec_drop = 1'b1;
  endfunction

  // Plain UTF-8 encoding of a 21-bit codepoint, 1 to 4 bytes.
  function automatic void utf8_encode(input logic [20:0] cp, output logic [7:0] enc[4],
                                      output int n);
    if (cp < 21'h80) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n = 4;
    end
  endfunction

  // Byte-level alphabet: bit 8 set means the codepoint has no byte.
  function automatic logic [8:0] alphabet_lookup(logic [20:0] cp);
    logic [20:0] n;
    if (cp >= ALPHABET_SIZE) return 9'h100;
    if (cp < 21'd256) begin
      if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
          cp >= 21'd174)
        return {1'b0, cp[7:0]};
      return 9'h100;
    end
    n = cp - 21'd256;
    if (n < 21'd33) return {1'b0, n[7:0]};
    if (n < 21'd67) begin
      n = n + 21'd94;
      return {1'b0, n[7:0]};
    end
    if (n == 21'd67) return {1'b0, 8'd173};
    return 9'h100;
  endfunction

  function automatic void emit_codepoint(logic [20:0] cp, logic last);
    logic [8:0] mapped;
    logic [7:0] enc[4];
    int         n;
    clear_decode();
    if (byte_mode) begin
      mapped = alphabet_lookup(cp);
      if (mapped[8]) report_error(ERR_OUTSIDE_ALPH, last);
      else push_result(mapped[7:0], ERR_NONE, 1'b1, last);
    end else begin
      utf8_encode(cp, enc, n);
      for (int i = 0; i < n; i++) push_result(enc[i], ERR_NONE, i == n - 1, last);
    end
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b0, t[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic void start_hex(jsud_phase_t next, logic last);
    if (last) begin
      report_error(ERR_TRUNC_HEX, last);
    end else begin
      dec_phase = next;
      dec_left  = 2'd3;
      dec_acc   = '0;
      dec_bad   = 1'b0;
    end
  endfunction

  function automatic void decode_step(logic [7:0] b, logic last);
    logic [4:0]  h;
    logic [15:0] v;
    case (dec_phase)
      PH_IDLE: begin
        if (b == CH_BSLASH) begin
          if (last) report_error(ERR_TRAIL_BSLASH, last);
          else dec_phase = PH_ESC;
        end else if (b < 8'h80) begin
          emit_codepoint({13'b0, b}, last);
        end else begin
          if (b[7:5] == 3'b110) begin
            dec_acc = {16'b0, b[4:0]};
            dec_left = 2'd0;
          end else if (b[7:4] == 4'b1110) begin
            dec_acc = {17'b0, b[3:0]};
            dec_left = 2'd1;
          end else if (b[7:3] == 5'b11110) begin
            dec_acc = {18'b0, b[2:0]};
            dec_left = 2'd2;
          end else begin
            report_error(ERR_BAD_LEAD, last);
            return;
          end
          if (last) begin
            report_error(ERR_TRUNC_UTF8, last);
          end else begin
            dec_bad = 1'b0;
            dec_phase = PH_UTF8;
          end
        end
      end
      PH_ESC: begin
        case (b)
          CH_QUOTE:  emit_codepoint(21'h22, last);
          CH_BSLASH: emit_codepoint(21'h5C, last);
          CH_SLASH:  emit_codepoint(21'h2F, last);
          CH_B:      emit_codepoint(21'h08, last);
          CH_F:      emit_codepoint(21'h0C, last);
          CH_N:      emit_codepoint(21'h0A, last);
          CH_R:      emit_codepoint(21'h0D, last);
          CH_T:      emit_codepoint(21'h09, last);
          CH_U:      start_hex(PH_HEX1, last);
          default:   report_error(ERR_UNKNOWN_ESC, last);
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        // A bad digit is only reported once all four digits are in.
        h = hex_value(b);
        if (h[4]) dec_bad = 1'b1;
        dec_acc = {5'b0, dec_acc[11:0], h[3:0]};
        if (dec_left != 2'd0) begin
          if (last) report_error(ERR_TRUNC_HEX, last);
          else dec_left = dec_left - 2'd1;
        end else if (dec_bad) begin
          report_error(ERR_BAD_HEX, last);
        end else begin
          v = dec_acc[15:0];
          if (dec_phase == PH_HEX2) begin
            if (v < 16'hDC00 || v > 16'hDFFF) report_error(ERR_BAD_PAIR, last);
            else emit_codepoint(21'h10000 + {dec_high, 10'b0} + (v - 16'hDC00), last);
          end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
            if (last) begin
              report_error(ERR_UNPAIRED_HI, last);
            end else begin
              dec_high  = v[9:0];
              dec_acc   = '0;
              dec_phase = PH_HIGH_BS;
            end
          end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
            report_error(ERR_UNPAIRED_LO, last);
          end else begin
            emit_codepoint({5'b0, v}, last);
          end
        end
      end
      PH_HIGH_BS: begin
        if (b != CH_BSLASH || last) report_error(ERR_UNPAIRED_HI, last);
        else dec_phase = PH_HIGH_U;
      end
      PH_HIGH_U: begin
        if (b != CH_U) report_error(ERR_UNPAIRED_HI, last);
        else start_hex(PH_HEX2, last);
      end
      PH_UTF8: begin
        // A bad continuation is only reported once the whole sequence is in.
        if (b[7:6] != 2'b10) dec_bad = 1'b1;
        dec_acc = {dec_acc[14:0], b[5:0]};
        if (dec_left != 2'd0) begin
          if (last) report_error(ERR_TRUNC_UTF8, last);
          else dec_left = dec_left - 2'd1;
        end else if (dec_bad) begin
          report_error(ERR_BAD_CONT, last);
        end else begin
          emit_codepoint(dec_acc, last);
        end
      end
      default: clear_decode();
    endcase
  endfunction

  // One accepted input byte; a string end always brings the decoder back to idle.
  function automatic void decode_byte(logic [7:0] b, logic last);
    if (dec_drop) begin
      if (last) dec_drop = 1'b0;
      clear_decode();
      return;
    end
    decode_step(b, last);
    if (last) begin
      clear_decode();
      dec_drop = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake processes
  // ---------------------------------------------------------------------------

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!out_idle_on) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    jsud_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected result byte=%02h err=%0d run_last=%b end=%b", $time,
                 out_data.out_byte, out_data.error_code, out_data.run_last,
                 out_data.string_end);
        errors = errors + 1;
      end else begin
        want = decoded_due.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected byte=%02h err=%0d run_last=%b end=%b",
                   $time, want.out_byte, want.error_code, want.run_last, want.string_end);
          $display("%0t:          actual   byte=%02h err=%0d run_last=%b end=%b",
                   $time, out_data.out_byte, out_data.error_code, out_data.run_last,
                   out_data.string_end);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Drive one byte and wait for its transfer; valid stays high afterwards.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = {b, last};
    do @(posedge clk); while (in_stall);
    decode_byte(b, last);
    sent_items = sent_items + 1;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (decoded_due.size() != 0) @(posedge clk);
  endtask

  // Mode changes only once the block has gone quiet.
  task automatic write_mode(logic mode);
    drain_results();
    repeat (CFG_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = mode;
    do @(posedge clk); while (!cfg_ready);
    byte_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Appends one byte to the string being built.
  function automatic void add_byte(logic [7:0] b);
    str_bytes = {str_bytes, b};
  endfunction

  task automatic send_built();
    for (int i = 0; i < str_bytes.size(); i++) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  task automatic send_text(string s);
    str_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_built();
  endtask

  // ---------------------------------------------------------------------------
  // Random string bodies
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_uesc(logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_byte(hex_char(v[15:12]));
    add_byte(hex_char(v[11:8]));
    add_byte(hex_char(v[7:4]));
    add_byte(hex_char(v[3:0]));
  endfunction

  // Small codepoints dominate so the byte-level alphabet sees many hits.
  function automatic logic [20:0] pick_codepoint();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 21'($urandom_range(0, 600));
      4, 5:       return 21'($urandom_range(32'h80, 32'h7FF));
      6, 7:       return 21'($urandom_range(32'h800, 32'hFFFF));
      8:          return 21'($urandom_range(32'h10000, 32'h10FFFF));
      default:    return 21'($urandom_range(32'h110000, 32'h1FFFFF));
    endcase
  endfunction

  function automatic void add_clean_token();
    logic [20:0] cp;
    logic [19:0] off;
    logic [7:0]  b;
    logic [7:0]  enc[4];
    logic [7:0]  escapes[8];
    int          n;
    escapes = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == CH_BSLASH) add_byte(CH_BSLASH);
        add_byte(b);
      end
      3: begin
        b = 8'($urandom_range(0, 8'h1F));
        add_byte(b);
      end
      4: begin
        add_byte(CH_BSLASH);
        add_byte(escapes[$urandom_range(0, 7)]);
      end
      5, 6: begin
        cp = pick_codepoint();
        if (cp < 21'h10000) begin
          add_uesc(cp[15:0]);
        end else begin
          // Out-of-range codepoints fold back into the supplementary planes.
          off = cp[19:0];
          add_uesc({6'b110110, off[19:10]});
          add_uesc({6'b110111, off[9:0]});
        end
      end
      default: begin
        cp = pick_codepoint();
        utf8_encode(cp, enc, n);
        for (int i = 0; i < n; i++) add_byte(enc[i]);
      end
    endcase
  endfunction

  // Stray bytes, backslashes before a random byte and well-formed tokens with one byte spoiled.
  function automatic void add_noise_token();
    int start;
    case ($urandom_range(0, 2))
      0: add_byte(8'($urandom_range(0, 255)));
      1: begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        start = str_bytes.size();
        add_clean_token();
        str_bytes[$urandom_range(start, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // A string of random tokens, now and then cut short before its end.
  task automatic send_random_string(int max_tokens, int noise_pct);
    int tokens;
    int keep;
    str_bytes.delete();
    tokens = $urandom_range(1, max_tokens);
    for (int i = 0; i < tokens; i++) begin
      if ($urandom_range(0, 99) < noise_pct) add_noise_token();
      else add_clean_token();
    end
    if (str_bytes.size() > 1 && $urandom_range(0, 99) < noise_pct) begin
      keep = $urandom_range(1, str_bytes.size() - 1);
      while (str_bytes.size() > keep) void'(str_bytes.pop_back());
    end
    send_built();
  endtask

  task automatic send_random_items(int count, int noise_pct);
    int target;
    target = sent_items + count;
    while (sent_items < target) send_random_string(6, noise_pct);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain bytes, a simple escape, a surrogate pair and raw UTF-8.
  task automatic test_literal_directed();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    write_mode(MODE_UTF8);
    send_text("A");
    str_bytes = '{8'h00};
    send_built();
    send_text("\\n");
    send_text("\\ud83d\\ude00");
    str_bytes = '{8'hC3, 8'hA9};
    send_built();
  endtask

  // Trailing backslash, truncation ahead of a bad digit, error then dropping.
  task automatic test_errors_directed();
    send_text("\\");
    send_text("\\u1g");
    str_bytes = '{8'hFF, 8'h78, 8'h79};
    send_built();
  endtask

  // Alphabet hits on both sides of 256 and a miss.
  task automatic test_byte_level_directed();
    write_mode(MODE_BYTE);
    str_bytes = '{8'hC5, 8'h83};
    send_built();
    send_text(" ");
    send_text("A");
  endtask

  // UTF-8 output under random idling, with one pause until all results are in.
  task automatic test_random_literal();
    write_mode(MODE_UTF8);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    send_random_items(50, 20);
    drain_results();
    send_random_items(60, 20);
  endtask

  // Byte-level output, first back to back, then with idling.
  task automatic test_random_byte_level();
    write_mode(MODE_BYTE);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_random_items(50, 15);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    send_random_items(50, 15);
  endtask

  // Mode flips back and forth between short bursts.
  task automatic test_mode_switching();
    for (int p = 0; p < 4; p++) begin
      write_mode(p[0] ? MODE_BYTE : MODE_UTF8);
      send_random_items(25, 25);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_literal_directed();
    test_errors_directed();
    test_byte_level_directed();
    test_random_literal();
    test_random_byte_level();
    test_mode_switching();

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0 && decoded_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
